// ===== rtl/scr_pkg.sv =====
// ----------------------------------------------------------------------------
// scr_pkg: shared definitions of the slope corridor key reducer
// Widths, limits and state types used by the reducer and its arithmetic units.
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam int VW = 32;
  localparam int TW = 31;
  localparam int DW = 16;
  localparam int NW = 34;
  localparam int QW = 33;
  localparam int PW = 50;
  localparam int YW = 51;

  localparam int MAX_SAMPLES = 65536;
  localparam logic [DW-1:0] IDX_LIMIT =
    (MAX_SAMPLES - 1 > 65535) ? 16'hFFFF : DW'(MAX_SAMPLES - 1);

  localparam logic signed [YW-1:0] SAT_HI = {{(YW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [YW-1:0] SAT_LO = {{(YW-VW+1){1'b1}}, {(VW-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS,
    ST_DIV,
    ST_CHK,
    ST_MUL,
    ST_SUM,
    ST_FIN,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_PREP,
    DV_STEP,
    DV_SIGN
  } dv_state_t;

endpackage

// ===== rtl/scr_in_if.sv =====
// ----------------------------------------------------------------------------
// scr_in_if: sample channel of the slope corridor key reducer
// Valid/ready channel that carries one track sample per beat.
// ----------------------------------------------------------------------------
interface scr_in_if;
  import scr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] sample_value;
  logic                 track_start;
  logic                 track_last;

  modport source (output valid, sample_value, track_start, track_last, input ready);
  modport sink (input valid, sample_value, track_start, track_last, output ready);

endinterface

// ===== rtl/scr_out_if.sv =====
// ----------------------------------------------------------------------------
// scr_out_if: key channel of the slope corridor key reducer
// Valid/ready channel that carries one emitted key per beat.
// ----------------------------------------------------------------------------
interface scr_out_if;
  import scr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DW-1:0]        key_time;
  logic signed [VW-1:0] key_value;
  logic                 run_last;
  logic                 track_done;

  modport source (output valid, key_time, key_value, run_last, track_done, input ready);
  modport sink (input valid, key_time, key_value, run_last, track_done, output ready);

endinterface

// ===== rtl/scr_div.sv =====
// ----------------------------------------------------------------------------
// scr_div: bit-serial signed divider
// Restoring division of a signed numerator by an unsigned distance, one
// quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module scr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [scr_pkg::NW-1:0] num,
  input  logic [scr_pkg::DW-1:0]        den,
  output logic                          done,
  output logic signed [scr_pkg::NW-1:0] quo
);
  import scr_pkg::*;

  localparam int CW = $clog2(QW + 1);

  dv_state_t            dst_r, dst_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic signed [NW-1:0] num_r, num_nxt;
  logic [QW-1:0]        qsh_r, qsh_nxt;
  logic [DW-1:0]        rem_r, rem_nxt;
  logic [DW-1:0]        den_r, den_nxt;
  logic                 neg_r, neg_nxt;
  logic signed [NW-1:0] quo_r, quo_nxt;
  logic                 done_r, done_nxt;

  logic [DW:0]          trial;
  logic [DW:0]          diff;
  logic                 fits;
  logic [NW-1:0]        mag;

  assign trial = {rem_r, qsh_r[QW-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};
  assign mag   = num_r[NW-1] ? NW'(-num_r) : NW'(num_r);

  always_comb begin
    dst_nxt  = dst_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    qsh_nxt  = qsh_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    done_nxt = 1'b0;
    unique case (dst_r)
      DV_IDLE: begin
        if (start) begin
          num_nxt = num;
          den_nxt = den;
          dst_nxt = DV_PREP;
        end
      end
      DV_PREP: begin
        neg_nxt = num_r[NW-1];
        qsh_nxt = mag[QW-1:0];
        rem_nxt = '0;
        cnt_nxt = CW'(QW);
        dst_nxt = DV_STEP;
      end
      DV_STEP: begin
        rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];
        qsh_nxt = {qsh_r[QW-2:0], fits};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          dst_nxt = DV_SIGN;
        end
      end
      DV_SIGN: begin
        quo_nxt  = neg_r ? -$signed({1'b0, qsh_r}) : $signed({1'b0, qsh_r});
        done_nxt = 1'b1;
        dst_nxt  = DV_IDLE;
      end
      default: dst_nxt = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst_r  <= DV_IDLE;
      done_r <= 1'b0;
    end else begin
      dst_r  <= dst_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    qsh_r <= qsh_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/scr_mul.sv =====
// ----------------------------------------------------------------------------
// scr_mul: bit-serial slope multiplier
// Multiplies a signed slope by an unsigned distance, one distance bit per
// cycle, most significant bit first.
// ----------------------------------------------------------------------------
module scr_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [scr_pkg::NW-1:0] mcand,
  input  logic [scr_pkg::DW-1:0]        mplier,
  output logic                          done,
  output logic signed [scr_pkg::PW-1:0] prod
);
  import scr_pkg::*;

  localparam int MCW = $clog2(DW + 1);

  logic [MCW-1:0]       cnt_r, cnt_nxt;
  logic signed [PW-1:0] acc_r, acc_nxt;
  logic signed [NW-1:0] mc_r, mc_nxt;
  logic [DW-1:0]        msh_r, msh_nxt;
  logic                 done_r, done_nxt;
  logic signed [PW-1:0] mc_ext;

  assign mc_ext = $signed({{(PW-NW){mc_r[NW-1]}}, mc_r});

  always_comb begin
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    msh_nxt  = msh_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = MCW'(DW);
      acc_nxt = '0;
      mc_nxt  = mcand;
      msh_nxt = mplier;
    end else if (cnt_r != '0) begin
      acc_nxt  = (acc_r <<< 1) + (msh_r[DW-1] ? mc_ext : '0);
      msh_nxt  = {msh_r[DW-2:0], 1'b0};
      cnt_nxt  = cnt_r - MCW'(1);
      done_nxt = (cnt_r == MCW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    msh_r <= msh_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== rtl/slope_corridor_key_reducer.sv =====
// ----------------------------------------------------------------------------
// slope_corridor_key_reducer: swinging-door key reduction of a sampled track
// Keeps the last key and a corridor of slopes, narrows it per sample through
// two bit-serial dividers, and places keys through two bit-serial multipliers.
//
//   channel  dir  handshake      beat contents
//   in_ch    in   valid/ready    sample_value, track_start, track_last
//   out_ch   out  valid/ready    key_time, key_value, run_last, track_done
//   cfg      in   cfg_we         cfg_wdata (tolerance)
//
// The first sample of a track goes straight to the emit state. A sample that
// emits nothing is run through the 33-step divider; placing a key adds the
// 16-step multiplier, and a sample that closes a key inside the track is
// divided again unless it is the last sample of the track.
// One sample is worked on at a time; a new sample is taken while the last key
// still waits in the output register. A further key waits in the emit state
// until that register is free, which holds off the input. Reset is synchronous.
// ----------------------------------------------------------------------------
module slope_corridor_key_reducer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [scr_pkg::TW-1:0] cfg_wdata,
  scr_in_if.sink                 in_ch,
  scr_out_if.source              out_ch
);
  import scr_pkg::*;

  state_t               state_r, state_nxt;
  logic [TW-1:0]        tol_r;
  logic [DW-1:0]        key_time_r, key_time_nxt;
  logic signed [VW-1:0] key_val_r, key_val_nxt;
  logic signed [NW-1:0] slope_lo_r, slope_lo_nxt;
  logic signed [NW-1:0] slope_hi_r, slope_hi_nxt;
  logic                 open_r, open_nxt;
  logic [DW-1:0]        sample_idx_r, sample_idx_nxt;
  logic                 in_track_r, in_track_nxt;
  logic signed [VW-1:0] samp_r, samp_nxt;
  logic                 last_r, last_nxt;
  logic                 viol_r, viol_nxt;
  logic                 vsel_hi_r, vsel_hi_nxt;
  logic                 emit_pass_r, emit_pass_nxt;
  logic signed [YW-1:0] y_lo_r, y_lo_nxt;
  logic signed [YW-1:0] y_hi_r, y_hi_nxt;
  logic [DW-1:0]        res_time_r, res_time_nxt;
  logic signed [VW-1:0] res_val_r, res_val_nxt;
  logic                 res_rl_r, res_rl_nxt;
  logic                 res_done_r, res_done_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DW-1:0]        out_time_r, out_time_nxt;
  logic signed [VW-1:0] out_val_r, out_val_nxt;
  logic                 out_rl_r, out_rl_nxt;
  logic                 out_done_r, out_done_nxt;

  logic [DW:0]          n_ext;
  logic                 ovf;
  logic [DW-1:0]        n_val;
  logic [DW-1:0]        gap;
  logic                 exact;
  logic signed [NW-1:0] samp_x, tol_x, key_x;
  logic signed [NW-1:0] num_lo, num_hi;
  logic                 div_start;
  logic                 div_lo_done, div_hi_done;
  logic signed [NW-1:0] q_lo, q_hi;
  logic                 below_lo, above_hi, viol;
  logic signed [NW-1:0] new_lo, new_hi;
  logic                 mul_start;
  logic signed [NW-1:0] mul_lo_mc, mul_hi_mc;
  logic [DW-1:0]        mul_m;
  logic                 mul_lo_done, mul_hi_done;
  logic signed [PW-1:0] prod_lo, prod_hi;
  logic signed [YW-1:0] key_y, samp_y, prod_lo_y, prod_hi_y;
  logic signed [YW-1:0] y_sel, y_clamp;
  logic signed [VW-1:0] fin_val;

  function automatic logic signed [VW-1:0] sat_val(input logic signed [YW-1:0] v);
    logic signed [VW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[VW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[VW-1:0];
    end else begin
      r = v[VW-1:0];
    end
    return r;
  endfunction

  assign n_ext = {1'b0, sample_idx_r} + (DW+1)'(1);
  assign ovf   = n_ext >= {1'b0, IDX_LIMIT};
  assign n_val = ovf ? IDX_LIMIT : n_ext[DW-1:0];
  assign gap   = sample_idx_r - key_time_r;
  assign exact = last_r && (gap == DW'(1));

  assign samp_x = $signed({{(NW-VW){samp_r[VW-1]}}, samp_r});
  assign tol_x  = $signed({{(NW-TW){1'b0}}, tol_r});
  assign key_x  = $signed({{(NW-VW){key_val_r[VW-1]}}, key_val_r});
  assign num_lo = samp_x - tol_x - key_x;
  assign num_hi = samp_x + tol_x - key_x;

  assign below_lo = q_hi < slope_lo_r;
  assign above_hi = q_lo > slope_hi_r;
  assign viol     = !open_r && (below_lo || above_hi);
  assign new_hi   = (open_r || q_hi < slope_hi_r) ? q_hi : slope_hi_r;
  assign new_lo   = (open_r || q_lo > slope_lo_r) ? q_lo : slope_lo_r;

  assign key_y     = $signed({{(YW-VW){key_val_r[VW-1]}}, key_val_r});
  assign samp_y    = $signed({{(YW-VW){samp_r[VW-1]}}, samp_r});
  assign prod_lo_y = $signed({{(YW-PW){prod_lo[PW-1]}}, prod_lo});
  assign prod_hi_y = $signed({{(YW-PW){prod_hi[PW-1]}}, prod_hi});

  assign y_sel   = vsel_hi_r ? y_hi_r : y_lo_r;
  assign y_clamp = (samp_y < y_lo_r) ? y_lo_r : ((samp_y > y_hi_r) ? y_hi_r : samp_y);
  assign fin_val = sat_val(viol_r ? y_sel : y_clamp);

  scr_div u_div_lo (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_lo),
    .den   (gap),
    .done  (div_lo_done),
    .quo   (q_lo)
  );

  scr_div u_div_hi (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_hi),
    .den   (gap),
    .done  (div_hi_done),
    .quo   (q_hi)
  );

  scr_mul u_mul_lo (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_lo_mc),
    .mplier (mul_m),
    .done   (mul_lo_done),
    .prod   (prod_lo)
  );

  scr_mul u_mul_hi (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_hi_mc),
    .mplier (mul_m),
    .done   (mul_hi_done),
    .prod   (prod_hi)
  );

  always_comb begin
    state_nxt      = state_r;
    key_time_nxt   = key_time_r;
    key_val_nxt    = key_val_r;
    slope_lo_nxt   = slope_lo_r;
    slope_hi_nxt   = slope_hi_r;
    open_nxt       = open_r;
    sample_idx_nxt = sample_idx_r;
    in_track_nxt   = in_track_r;
    samp_nxt       = samp_r;
    last_nxt       = last_r;
    viol_nxt       = viol_r;
    vsel_hi_nxt    = vsel_hi_r;
    emit_pass_nxt  = emit_pass_r;
    y_lo_nxt       = y_lo_r;
    y_hi_nxt       = y_hi_r;
    res_time_nxt   = res_time_r;
    res_val_nxt    = res_val_r;
    res_rl_nxt     = res_rl_r;
    res_done_nxt   = res_done_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_time_nxt   = out_time_r;
    out_val_nxt    = out_val_r;
    out_rl_nxt     = out_rl_r;
    out_done_nxt   = out_done_r;
    div_start      = 1'b0;
    mul_start      = 1'b0;
    mul_lo_mc      = slope_lo_r;
    mul_hi_mc      = slope_hi_r;
    mul_m          = gap - DW'(1);
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          samp_nxt = in_ch.sample_value;
          if (in_ch.track_start || !in_track_r) begin
            sample_idx_nxt = '0;
            key_time_nxt   = '0;
            key_val_nxt    = in_ch.sample_value;
            open_nxt       = 1'b1;
            in_track_nxt   = !in_ch.track_last;
            res_time_nxt   = '0;
            res_val_nxt    = in_ch.sample_value;
            res_rl_nxt     = 1'b1;
            res_done_nxt   = in_ch.track_last;
            emit_pass_nxt  = 1'b0;
            state_nxt      = ST_EMIT;
          end else begin
            sample_idx_nxt = n_val;
            last_nxt       = in_ch.track_last || ovf;
            state_nxt      = ST_PASS;
          end
        end
      end
      ST_PASS: begin
        if (exact) begin
          key_time_nxt  = sample_idx_r;
          key_val_nxt   = samp_r;
          in_track_nxt  = 1'b0;
          res_time_nxt  = sample_idx_r;
          res_val_nxt   = samp_r;
          res_rl_nxt    = 1'b1;
          res_done_nxt  = 1'b1;
          emit_pass_nxt = 1'b0;
          state_nxt     = ST_EMIT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_lo_done) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        viol_nxt    = viol;
        vsel_hi_nxt = !below_lo;
        if (viol) begin
          mul_start = 1'b1;
          state_nxt = ST_MUL;
        end else begin
          slope_lo_nxt = new_lo;
          slope_hi_nxt = new_hi;
          open_nxt     = 1'b0;
          if (last_r) begin
            mul_start = 1'b1;
            mul_lo_mc = new_lo;
            mul_hi_mc = new_hi;
            mul_m     = gap;
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MUL: begin
        if (mul_lo_done) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        y_lo_nxt  = key_y + prod_lo_y;
        y_hi_nxt  = key_y + prod_hi_y;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        key_val_nxt = fin_val;
        res_val_nxt = fin_val;
        if (viol_r) begin
          key_time_nxt  = sample_idx_r - DW'(1);
          open_nxt      = 1'b1;
          res_time_nxt  = sample_idx_r - DW'(1);
          res_rl_nxt    = !last_r;
          res_done_nxt  = 1'b0;
          emit_pass_nxt = 1'b1;
        end else begin
          key_time_nxt  = sample_idx_r;
          in_track_nxt  = 1'b0;
          res_time_nxt  = sample_idx_r;
          res_rl_nxt    = 1'b1;
          res_done_nxt  = 1'b1;
          emit_pass_nxt = 1'b0;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_time_nxt  = res_time_r;
          out_val_nxt   = res_val_r;
          out_rl_nxt    = res_rl_r;
          out_done_nxt  = res_done_r;
          state_nxt     = emit_pass_r ? ST_PASS : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tol_r        <= '0;
      key_time_r   <= '0;
      key_val_r    <= '0;
      slope_lo_r   <= '0;
      slope_hi_r   <= '0;
      open_r       <= 1'b1;
      sample_idx_r <= '0;
      in_track_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tol_r        <= cfg_we ? cfg_wdata : tol_r;
      key_time_r   <= key_time_nxt;
      key_val_r    <= key_val_nxt;
      slope_lo_r   <= slope_lo_nxt;
      slope_hi_r   <= slope_hi_nxt;
      open_r       <= open_nxt;
      sample_idx_r <= sample_idx_nxt;
      in_track_r   <= in_track_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_r      <= samp_nxt;
    last_r      <= last_nxt;
    viol_r      <= viol_nxt;
    vsel_hi_r   <= vsel_hi_nxt;
    emit_pass_r <= emit_pass_nxt;
    y_lo_r      <= y_lo_nxt;
    y_hi_r      <= y_hi_nxt;
    res_time_r  <= res_time_nxt;
    res_val_r   <= res_val_nxt;
    res_rl_r    <= res_rl_nxt;
    res_done_r  <= res_done_nxt;
    out_time_r  <= out_time_nxt;
    out_val_r   <= out_val_nxt;
    out_rl_r    <= out_rl_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.key_time   = out_time_r;
  assign out_ch.key_value  = out_val_r;
  assign out_ch.run_last   = out_rl_r;
  assign out_ch.track_done = out_done_r;

  // The two dividers and the two multipliers are started together and must
  // finish together.
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    div_lo_done == div_hi_done)
    else $error("divider lanes out of step");

  a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    mul_lo_done == mul_hi_done)
    else $error("multiplier lanes out of step");

  a_corridor_order: assert property (@(posedge clk) disable iff (!rst_n)
    !open_r |-> slope_lo_r <= slope_hi_r)
    else $error("slope corridor is inverted");

  a_key_behind: assert property (@(posedge clk) disable iff (!rst_n)
    key_time_r <= sample_idx_r)
    else $error("key lies ahead of the current sample");

endmodule

// ===== sim/slope_corridor_key_reducer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slope_corridor_key_reducer_tb: self-checking bench of the key reducer
// Drives sample beats from a directed table, then from random tracks; takes
// typed rows' keys from the table, predicts the others with a behavioral
// corridor model, and compares each key field under random idles and stalls.
// ----------------------------------------------------------------------------
module slope_corridor_key_reducer_tb;
  import scr_pkg::*;

  localparam int     RAND_ITEMS  = 260;
  localparam int     DRAIN_WAIT  = 200;
  localparam int     HOLD_CYCLES = 1500;
  localparam int     WDOG_LIMIT  = 6000;
  localparam int     DIR_ROWS    = 26;
  localparam longint VAL_MAX     = 64'sd2147483647;
  localparam longint VAL_MIN     = -64'sd2147483648;
  localparam longint SLOPE_FLOOR = -64'sd140737488355328;
  localparam longint SLOPE_CEIL  = 64'sd140737488355327;
  localparam longint SLOPE_CLAMP = 64'sd70368744177664;

  typedef struct packed {
    logic [15:0]        key_time;
    logic signed [31:0] key_value;
    logic               run_last;
    logic               track_done;
  } key_beat_t;

  typedef enum logic {ROW_SAMPLE, ROW_TOL} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] val;
    logic        start;
    logic        last;
    logic        typed;
    key_beat_t   want;
  } dir_row_t;

  localparam key_beat_t NO_KEY = '0;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           cfg_we;
  logic [TW-1:0]  cfg_wdata;

  scr_in_if  in_ch ();
  scr_out_if out_ch ();

  slope_corridor_key_reducer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  key_beat_t key_q[$];
  key_beat_t fresh_keys[$];
  int        n_errors = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  bit        hold_req = 1'b0;
  int        quiet_cycles = 0;

  logic [TW-1:0] tol_r = '0;
  longint        key_t = 0;
  longint        key_v = 0;
  longint        slope_lo = SLOPE_FLOOR;
  longint        slope_hi = SLOPE_CEIL;
  longint        smp_idx = 0;
  bit            track_open = 1'b0;

  dir_row_t dir_tab [0:DIR_ROWS-1];

  function automatic longint sat32(input longint v);
    if (v > VAL_MAX) return VAL_MAX;
    if (v < VAL_MIN) return VAL_MIN;
    return v;
  endfunction

  function automatic longint along_slope(input longint slope, input longint gap);
    if (slope > SLOPE_CLAMP) slope = SLOPE_CLAMP;
    if (slope < -SLOPE_CLAMP) slope = -SLOPE_CLAMP;
    return key_v + slope * (gap & 64'hFFFF);
  endfunction

  function automatic void push_key(input longint t, input longint v, input bit done);
    key_beat_t kb;
    kb.key_time   = t[15:0];
    kb.key_value  = v[31:0];
    kb.run_last   = 1'b0;
    kb.track_done = done;
    fresh_keys.insert(fresh_keys.size(), kb);
  endfunction

  function automatic void reduce_sample(input logic signed [31:0] smp, input bit start,
                                        input bit last_in);
    longint    s, tol, lim, n, d, lo_n, hi_n, b, v, ymin, ymax;
    bit        last;
    int        p;
    s = smp;
    tol = tol_r;
    last = last_in;
    fresh_keys.delete();
    lim = IDX_LIMIT;
    if (lim < 1) lim = 1;
    if (start || !track_open) begin
      smp_idx = 0;
      key_t = 0;
      key_v = sat32(s);
      slope_lo = SLOPE_FLOOR;
      slope_hi = SLOPE_CEIL;
      track_open = !last;
      push_key(0, key_v, last);
    end else begin
      n = smp_idx + 1;
      if (n >= lim) begin
        n = lim;
        last = 1'b1;
      end
      smp_idx = n;
      for (p = 0; p < 2; p++) begin
        if (last && n == key_t + 1) begin
          key_t = n;
          key_v = sat32(s);
          push_key(n, key_v, 1'b1);
          track_open = 1'b0;
          break;
        end
        d = n - key_t;
        if (d == 0) d = 1;
        lo_n = (s - tol - key_v) / d;
        hi_n = (s + tol - key_v) / d;
        if (hi_n < slope_lo || lo_n > slope_hi) begin
          b = (hi_n < slope_lo) ? slope_lo : slope_hi;
          v = sat32(along_slope(b, d - 1));
          key_t = n - 1;
          key_v = v;
          slope_lo = SLOPE_FLOOR;
          slope_hi = SLOPE_CEIL;
          push_key(n - 1, v, 1'b0);
          continue;
        end
        if (hi_n < slope_hi) slope_hi = hi_n;
        if (lo_n > slope_lo) slope_lo = lo_n;
        if (last) begin
          ymin = along_slope(slope_lo, d);
          ymax = along_slope(slope_hi, d);
          v = s;
          if (s < ymin) v = ymin;
          else if (s > ymax) v = ymax;
          key_t = n;
          key_v = sat32(v);
          push_key(n, key_v, 1'b1);
          track_open = 1'b0;
        end
        break;
      end
    end
    if (fresh_keys.size() > 0) begin
      fresh_keys[fresh_keys.size() - 1].run_last = 1'b1;
    end
  endfunction

  task automatic send_sample(input logic signed [31:0] val, input bit start, input bit last,
                             input bit typed, input key_beat_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample_value <= val;
    in_ch.track_start  <= start;
    in_ch.track_last   <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    reduce_sample(val, start, last);
    if (typed) key_q.insert(key_q.size(), want);
    else foreach (fresh_keys[k]) key_q.insert(key_q.size(), fresh_keys[k]);
  endtask

  task automatic settle;
    in_ch.valid <= 1'b0;
    while (key_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_tolerance(input logic [TW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tol_r = v;
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_keys
    key_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (key_q.size() == 0) begin
        $display("%0t: key beat with none expected: actual time %0d value %h", $time,
                 out_ch.key_time, out_ch.key_value);
        n_errors++;
      end else begin
        want = key_q.pop_front();
        if (out_ch.key_time !== want.key_time) begin
          $display("%0t: key_time expected %0d actual %0d", $time, want.key_time,
                   out_ch.key_time);
          n_errors++;
        end
        if (out_ch.key_value !== want.key_value) begin
          $display("%0t: key_value expected %h actual %h", $time, want.key_value,
                   out_ch.key_value);
          n_errors++;
        end
        if (out_ch.run_last !== want.run_last) begin
          $display("%0t: run_last expected %b actual %b", $time, want.run_last,
                   out_ch.run_last);
          n_errors++;
        end
        if (out_ch.track_done !== want.track_done) begin
          $display("%0t: track_done expected %b actual %b", $time, want.track_done,
                   out_ch.track_done);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WDOG_LIMIT) begin
      $display("slope_corridor_key_reducer_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                 ph, items, len, i;
    bit                 drop_last;
    logic signed [31:0] v, step;
    dir_tab = '{
      '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, '{16'd0, 32'h7FFF_FFFF, 1'b1, 1'b0}},
      '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b0, 1'b0, NO_KEY},
      '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 1'b0, NO_KEY},
      '{ROW_SAMPLE, 32'h0000_0000, 1'b1, 1'b1, 1'b1, '{16'd0, 32'h0000_0000, 1'b1, 1'b1}},
      '{ROW_SAMPLE, 32'h0005_0000, 1'b1, 1'b0, 1'b1, '{16'd0, 32'h0005_0000, 1'b1, 1'b0}},
      '{ROW_SAMPLE, 32'h0007_0000, 1'b0, 1'b1, 1'b1, '{16'd1, 32'h0007_0000, 1'b1, 1'b1}},
      '{ROW_SAMPLE, 32'h0001_0000, 1'b1, 1'b0, 1'b1, '{16'd0, 32'h0001_0000, 1'b1, 1'b0}},
      '{ROW_SAMPLE, 32'h0002_0000, 1'b0, 1'b0, 1'b0, NO_KEY},
      '{ROW_SAMPLE, 32'hFFFF_0000, 1'b1, 1'b0, 1'b1, '{16'd0, 32'hFFFF_0000, 1'b1, 1'b0}},
      '{ROW_SAMPLE, 32'h0000_0000, 1'b0, 1'b0, 1'b0, NO_KEY},
      '{ROW_SAMPLE, 32'h0001_0000, 1'b0, 1'b0, 1'b0, NO_KEY},
      '{ROW_SAMPLE, 32'h0003_0000, 1'b0, 1'b0, 1'b0, NO_KEY},
      '{ROW_SAMPLE, 32'h0004_0000, 1'b0, 1'b1, 1'b0, NO_KEY},
      '{ROW_TOL,    32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, NO_KEY},
      '{ROW_SAMPLE, 32'h8000_0000, 1'b1, 1'b0, 1'b1, '{16'd0, 32'h8000_0000, 1'b1, 1'b0}},
      '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, NO_KEY},
      '{ROW_SAMPLE, 32'h1234_5678, 1'b0, 1'b0, 1'b0, NO_KEY},
      '{ROW_SAMPLE, 32'h8000_0001, 1'b0, 1'b1, 1'b0, NO_KEY},
      '{ROW_TOL,    32'h0000_8000, 1'b0, 1'b0, 1'b0, NO_KEY},
      '{ROW_SAMPLE, 32'h0000_0000, 1'b1, 1'b0, 1'b1, '{16'd0, 32'h0000_0000, 1'b1, 1'b0}},
      '{ROW_SAMPLE, 32'h0000_C000, 1'b0, 1'b0, 1'b0, NO_KEY},
      '{ROW_SAMPLE, 32'hFFFF_0000, 1'b0, 1'b0, 1'b0, NO_KEY},
      '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, NO_KEY},
      '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, NO_KEY},
      '{ROW_SAMPLE, 32'h5555_5555, 1'b0, 1'b1, 1'b1, '{16'd0, 32'h5555_5555, 1'b1, 1'b1}},
      '{ROW_SAMPLE, 32'hAAAA_AAAA, 1'b1, 1'b0, 1'b1, '{16'd0, 32'hAAAA_AAAA, 1'b1, 1'b0}}
    };

    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.sample_value   <= '0;
    in_ch.track_start    <= 1'b0;
    in_ch.track_last     <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].kind == ROW_TOL) begin
        settle();
        set_tolerance(dir_tab[i].val[TW-1:0]);
      end else begin
        send_sample(dir_tab[i].val, dir_tab[i].start, dir_tab[i].last, dir_tab[i].typed,
                    dir_tab[i].want);
      end
    end
    settle();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          set_tolerance(31'h0000_4000);
        end
        1: begin
          idle_pct = 77;
          stall_pct = 0;
          set_tolerance(TW'($urandom_range(32'h0004_0000, 0)));
        end
        2: begin
          idle_pct = 0;
          stall_pct = 77;
          set_tolerance('0);
        end
        default: begin
          idle_pct = 7;
          stall_pct = 7;
          set_tolerance(TW'($urandom_range(32'h0010_0000, 0)));
        end
      endcase
      if (ph == 0) hold_req = 1'b1;
      items = 0;
      while (items < RAND_ITEMS) begin
        if ($urandom_range(99) < 80) begin
          len = ($urandom_range(19) == 0) ? $urandom_range(300, 40) : $urandom_range(12, 1);
          if (len > RAND_ITEMS - items) len = RAND_ITEMS - items;
          drop_last = ($urandom_range(9) == 0);
          v = $urandom;
          step = $signed($urandom) >>> $urandom_range(20, 10);
          for (int j = 0; j < len; j++) begin
            if ($urandom_range(7) == 0) step = $signed($urandom) >>> $urandom_range(20, 10);
            send_sample(v, j == 0, (j == len - 1) && !drop_last, 1'b0, NO_KEY);
            v = v + step + ($signed($urandom) >>> $urandom_range(24, 12));
            items++;
          end
        end else begin
          send_sample($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, NO_KEY);
          items++;
        end
      end
      settle();
    end

    if (n_errors == 0) begin
      $display("slope_corridor_key_reducer_tb OK");
    end else begin
      $display("slope_corridor_key_reducer_tb NOT OK");
    end
    $finish;
  end

endmodule
